// File: rtl/seed_hit_block_chainer_core_defines.svh
// shared assertion macros for the seed hit block chainer
// each macro samples on clk and is quiet while rst is high
`ifndef SEED_HIT_BLOCK_CHAINER_CORE_DEFINES_SVH
`define SEED_HIT_BLOCK_CHAINER_CORE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define SHC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("shc assertion failed");

// consequent must hold in the cycle after the antecedent
`define SHC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("shc assertion failed");

`endif

// File: rtl/shc_pkg.sv
`timescale 1ns / 1ps

package shc_pkg;

  localparam int POS_WIDTH    = 32;
  localparam int SEQ_ID_WIDTH = 16;
  localparam int KMER_WIDTH   = 8;
  localparam int MINRUN_WIDTH = 16;
  localparam int CFG_WIDTH    = 16;

  localparam logic [POS_WIDTH-1:0] POS_MAX = '1;

  // output queue sizing
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_KMER_SIZE      = 1'b0,
    REG_MIN_RUN_LENGTH = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic                    end_of_contig;
    logic                    hit_found;
    logic [POS_WIDTH-1:0]    query_pos;
    logic [POS_WIDTH-1:0]    ref_pos;
    logic [SEQ_ID_WIDTH-1:0] ref_seq_id;
  } in_word_t;

  typedef struct packed {
    logic                    block_valid;
    logic [POS_WIDTH-1:0]    block_ref_start;
    logic [POS_WIDTH-1:0]    block_query_start;
    logic [POS_WIDTH-1:0]    block_length;
    logic [SEQ_ID_WIDTH-1:0] block_seq_id;
    logic                    last_of_contig;
  } out_word_t;

  // up to two result words handed from the engine to the output queue
  typedef struct packed {
    logic [1:0] n_words;
    out_word_t  w0;
    out_word_t  w1;
  } push_t;

endpackage

// File: rtl/seed_hit_block_chainer_core.sv
`timescale 1ns / 1ps
// seed hit block chainer
// input channel (in_valid/in_ready/in_data) takes one k-mer lookup word per
// query position; output channel (out_valid/out_ready/out_data) gives block
// words. a miss gives nothing, a hit closing a run gives at most one word,
// an end-of-contig word gives one or two words, the last with last_of_contig.
// an accepted word is registered in the input register, processed from there
// once the queue has room, and its results are written into the queue and
// read from its head onto out_data.
// throughput: one input word per cycle while the output side keeps up; the
// chaining update is combinational compare and add logic.
// the results go into a four entry queue; an input word is processed only
// while the queue has room for two words, the most that one word can give, so
// a stalled receiver backs up into in_ready after at most a few words.
// config: cfg_we writes cfg_wdata into register cfg_index (0 kmer_size,
// 1 min_run_length); user must write only while the block is idle, unenforced.
// reset (rst, synchronous): clears chaining state and the queue, kmer_size
// returns to 20 and min_run_length to 1.
module seed_hit_block_chainer_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  shc_pkg::in_word_t            in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output shc_pkg::out_word_t           out_data,
  input  logic                         cfg_we,
  input  logic [0:0]                   cfg_index,
  input  logic [shc_pkg::CFG_WIDTH-1:0] cfg_wdata
);
  import shc_pkg::*;

  logic [KMER_WIDTH-1:0]   kmer_size;
  logic [MINRUN_WIDTH-1:0] min_run_length;
  logic                    room_ok;
  push_t                   push;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_size      <= KMER_WIDTH'(20);
      min_run_length <= MINRUN_WIDTH'(1);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_KMER_SIZE:      kmer_size      <= cfg_wdata[KMER_WIDTH-1:0];
        REG_MIN_RUN_LENGTH: min_run_length <= cfg_wdata[MINRUN_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // chaining engine
  shc_engine u_engine (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .kmer_size      (kmer_size),
    .min_run_length (min_run_length),
    .room_ok        (room_ok),
    .push           (push)
  );

  // result queue
  shc_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room_ok   (room_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: rtl/shc_out_fifo.sv
`timescale 1ns / 1ps
`include "seed_hit_block_chainer_core_defines.svh"

module shc_out_fifo (
  input  logic              clk,
  input  logic              rst,
  input  shc_pkg::push_t    push,
  output logic              room_ok,
  output logic              out_valid,
  input  logic              out_ready,
  output shc_pkg::out_word_t out_data
);
  import shc_pkg::*;

  out_word_t          mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_CW-1:0] count;
  logic [FIFO_CW-1:0] count_next;
  logic               pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];
  // room for a full pair of words, regardless of a pop this cycle
  assign room_ok   = (count <= FIFO_CW'(FIFO_DEPTH - 2));

  assign count_next = count + FIFO_CW'(push.n_words) - FIFO_CW'(pop);

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_AW'(push.n_words);
      rd_ptr <= rd_ptr + FIFO_AW'(pop);
      count  <= count_next;
    end
  end

  // word storage
  always_ff @(posedge clk) begin
    if (push.n_words != 2'd0) begin
      mem[wr_ptr] <= push.w0;
    end
    if (push.n_words == 2'd2) begin
      mem[wr_ptr + FIFO_AW'(1)] <= push.w1;
    end
  end

  `SHC_ASSERT_SAME(a_count_bound, 1'b1, count <= FIFO_CW'(FIFO_DEPTH))
  `SHC_ASSERT_SAME(a_push_room, push.n_words != 2'd0,
                   (FIFO_CW + 1)'(count) + (FIFO_CW + 1)'(push.n_words)
                     <= (FIFO_CW + 1)'(FIFO_DEPTH))
  `SHC_ASSERT_NEXT(a_pop_only, pop && push.n_words == 2'd0,
                   count == $past(count) - FIFO_CW'(1))

endmodule

// File: rtl/shc_engine.sv
`timescale 1ns / 1ps
`include "seed_hit_block_chainer_core_defines.svh"

module shc_engine (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  shc_pkg::in_word_t                     in_data,
  input  logic [shc_pkg::KMER_WIDTH-1:0]        kmer_size,
  input  logic [shc_pkg::MINRUN_WIDTH-1:0]      min_run_length,
  input  logic                                  room_ok,
  output shc_pkg::push_t                        push
);
  import shc_pkg::*;

  // saturating add of the k-mer size onto a block length
  function automatic logic [POS_WIDTH-1:0] add_kmer(input logic [POS_WIDTH-1:0] len,
                                                    input logic [KMER_WIDTH-1:0] k);
    logic [POS_WIDTH:0] s;
    s = {1'b0, len} + (POS_WIDTH + 1)'(k);
    return s[POS_WIDTH] ? POS_MAX : s[POS_WIDTH-1:0];
  endfunction

  // input register
  in_word_t ibuf;
  logic     ibuf_valid;
  logic     proceed;

  // chaining state
  logic                    have_prev_hit;
  logic [POS_WIDTH-1:0]    prev_ref_pos;
  logic [SEQ_ID_WIDTH-1:0] prev_seq_id;
  logic                    run_open;
  logic [POS_WIDTH-1:0]    run_ref_start;
  logic [POS_WIDTH-1:0]    run_query_start;
  logic [POS_WIDTH-1:0]    run_len;
  logic                    held_valid;
  logic [POS_WIDTH-1:0]    held_ref_start;
  logic [POS_WIDTH-1:0]    held_query_start;
  logic [POS_WIDTH-1:0]    held_length;
  logic [SEQ_ID_WIDTH-1:0] held_seq_id;

  // held block after closing the open run
  logic                    held_valid_next;
  logic [POS_WIDTH-1:0]    held_ref_start_next;
  logic [POS_WIDTH-1:0]    held_query_start_next;
  logic [POS_WIDTH-1:0]    held_length_next;
  logic [SEQ_ID_WIDTH-1:0] held_seq_id_next;

  logic                 is_eoc;
  logic                 is_hit;
  logic                 cont;
  logic                 do_close;
  logic                 run_keep;
  logic                 r_borrow;
  logic                 q_borrow;
  logic [POS_WIDTH-1:0] dr;
  logic [POS_WIDTH-1:0] dq;
  logic                 same_diag;
  logic                 len_carry;
  logic [POS_WIDTH-1:0] len_sum;
  logic [POS_WIDTH-1:0] merge_len;
  logic                 do_merge;
  logic                 start_new;
  logic                 emit_old;
  out_word_t            old_word;
  out_word_t            final_word;

  assign proceed  = ibuf_valid && room_ok;
  assign in_ready = !ibuf_valid || room_ok;

  // input register control
  always_ff @(posedge clk) begin
    if (rst) begin
      ibuf_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      ibuf_valid <= 1'b1;
    end else if (proceed) begin
      ibuf_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ibuf <= in_data;
    end
  end

  // hit classification: does this hit extend the previous one
  assign is_eoc = ibuf.end_of_contig;
  assign is_hit = ibuf.hit_found && !ibuf.end_of_contig;
  assign cont   = have_prev_hit && (prev_seq_id == ibuf.ref_seq_id) &&
                  (prev_ref_pos != POS_MAX) &&
                  (ibuf.ref_pos == prev_ref_pos + POS_WIDTH'(1));

  assign do_close = run_open && (is_eoc || (is_hit && !cont));
  assign run_keep = run_len >= POS_WIDTH'(min_run_length);

  // diagonal check against the held block, both directions at once
  assign {r_borrow, dr} = {1'b0, run_ref_start} - {1'b0, held_ref_start};
  assign {q_borrow, dq} = {1'b0, run_query_start} - {1'b0, held_query_start};
  assign same_diag = held_valid && (held_seq_id == prev_seq_id) &&
                     (r_borrow == q_borrow) && (dr == dq);

  // merged length: grow when the run lies after, shrink (floor zero) before
  assign {len_carry, len_sum} = {1'b0, run_len} + {1'b0, dr};
  always_comb begin
    if (!r_borrow) begin
      merge_len = len_carry ? POS_MAX : len_sum;
    end else begin
      merge_len = len_carry ? len_sum : '0;
    end
  end

  assign do_merge  = do_close && run_keep && same_diag;
  assign start_new = do_close && run_keep && !same_diag;
  assign emit_old  = start_new && held_valid;

  always_comb begin
    held_valid_next       = held_valid;
    held_ref_start_next   = held_ref_start;
    held_query_start_next = held_query_start;
    held_length_next      = held_length;
    held_seq_id_next      = held_seq_id;
    if (do_merge) begin
      held_length_next = merge_len;
    end
    if (start_new) begin
      held_valid_next       = 1'b1;
      held_ref_start_next   = run_ref_start;
      held_query_start_next = run_query_start;
      held_length_next      = run_len;
      held_seq_id_next      = prev_seq_id;
    end
  end

  // result words
  always_comb begin
    old_word.block_valid       = 1'b1;
    old_word.block_ref_start   = held_ref_start;
    old_word.block_query_start = held_query_start;
    old_word.block_length      = add_kmer(held_length, kmer_size);
    old_word.block_seq_id      = held_seq_id;
    old_word.last_of_contig    = 1'b0;

    final_word = '0;
    final_word.last_of_contig = 1'b1;
    if (held_valid_next) begin
      final_word.block_valid       = 1'b1;
      final_word.block_ref_start   = held_ref_start_next;
      final_word.block_query_start = held_query_start_next;
      final_word.block_length      = add_kmer(held_length_next, kmer_size);
      final_word.block_seq_id      = held_seq_id_next;
    end
  end

  always_comb begin
    push.n_words = 2'd0;
    if (proceed) begin
      push.n_words = is_eoc ? (2'd1 + 2'(emit_old)) : 2'(emit_old);
    end
    push.w0 = emit_old ? old_word : final_word;
    push.w1 = final_word;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev_hit <= 1'b0;
      run_open      <= 1'b0;
      held_valid    <= 1'b0;
    end else if (proceed) begin
      if (is_eoc) begin
        have_prev_hit <= 1'b0;
        run_open      <= 1'b0;
        held_valid    <= 1'b0;
      end else if (is_hit) begin
        have_prev_hit <= 1'b1;
        if (cont) begin
          run_open <= 1'b1;
        end else if (run_open) begin
          run_open   <= 1'b0;
          held_valid <= held_valid_next;
        end
      end
    end
  end

  // payload state
  always_ff @(posedge clk) begin
    if (proceed && is_hit) begin
      prev_ref_pos <= ibuf.ref_pos;
      prev_seq_id  <= ibuf.ref_seq_id;
      if (cont) begin
        if (!run_open) begin
          run_ref_start   <= prev_ref_pos;
          run_query_start <= ibuf.query_pos - POS_WIDTH'(1);
          run_len         <= POS_WIDTH'(2);
        end else if (run_len != POS_MAX) begin
          run_len <= run_len + POS_WIDTH'(1);
        end
      end else if (run_open) begin
        held_ref_start   <= held_ref_start_next;
        held_query_start <= held_query_start_next;
        held_length      <= held_length_next;
        held_seq_id      <= held_seq_id_next;
      end
    end
  end

  `SHC_ASSERT_SAME(a_run_has_prev, run_open, have_prev_hit)
  `SHC_ASSERT_NEXT(a_eoc_clears, proceed && is_eoc,
                   !run_open && !held_valid && !have_prev_hit)
  `SHC_ASSERT_SAME(a_pair_ends_contig, push.n_words == 2'd2,
                   push.w1.last_of_contig && !push.w0.last_of_contig)

endmodule

// File: bench/seed_hit_block_chainer_core_tb.sv
`timescale 1ns / 1ps

module seed_hit_block_chainer_core_tb;
  import shc_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_WORDS = 285;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_data;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = '0;
  logic [CFG_WIDTH-1:0] cfg_wdata = '0;

  // lookup words waiting to be sent, block words waiting to be seen
  in_word_t lookup_q[$];
  out_word_t exp_blocks[$];

  int n_fail = 0;
  int n_work = 0;
  int in_gap = 0;
  int out_gap = 0;
  int stall_cnt = 0;
  bit calm = 1'b0;

  // chainer copy: registers
  logic [KMER_WIDTH-1:0] m_kmer = 8'd20;
  logic [MINRUN_WIDTH-1:0] m_minrun = 16'd1;

  // chainer copy: chaining state
  logic pv_hit;
  logic [POS_WIDTH-1:0] pv_ref;
  logic [SEQ_ID_WIDTH-1:0] pv_sid;
  logic rn_open;
  logic [POS_WIDTH-1:0] rn_ref0, rn_q0, rn_ref1;
  logic hd_valid;
  logic [POS_WIDTH-1:0] hd_ref0, hd_q0, hd_len;
  logic [SEQ_ID_WIDTH-1:0] hd_sid;

  seed_hit_block_chainer_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  always #4 clk = ~clk;

  // append to the pending lookup words and to the expected block words
  function automatic void queue_word(in_word_t w);
    lookup_q = {lookup_q, w};
  endfunction

  function automatic void expect_block(out_word_t o);
    exp_blocks = {exp_blocks, o};
  endfunction

  function automatic logic [POS_WIDTH-1:0] sat_sum(logic [POS_WIDTH-1:0] a,
                                                   logic [POS_WIDTH-1:0] b);
    logic [POS_WIDTH:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[POS_WIDTH] ? POS_MAX : s[POS_WIDTH-1:0];
  endfunction

  function automatic void chain_clear();
    pv_hit = 1'b0;
    pv_ref = '0;
    pv_sid = '0;
    rn_open = 1'b0;
    rn_ref0 = '0;
    rn_q0 = '0;
    rn_ref1 = '0;
    hd_valid = 1'b0;
    hd_ref0 = '0;
    hd_q0 = '0;
    hd_len = '0;
    hd_sid = '0;
  endfunction

  function automatic void push_held(logic last);
    out_word_t o;
    o.block_valid = 1'b1;
    o.block_ref_start = hd_ref0;
    o.block_query_start = hd_q0;
    o.block_length = sat_sum(hd_len, POS_WIDTH'(m_kmer));
    o.block_seq_id = hd_sid;
    o.last_of_contig = last;
    expect_block(o);
  endfunction

  // close the open run: drop it, merge it into the held block or replace it
  function automatic void close_run();
    logic [POS_WIDTH-1:0] diff, len, dd, newlen;
    logic merge;
    merge = 1'b0;
    newlen = '0;
    rn_open = 1'b0;
    diff = rn_ref1 - rn_ref0;
    len = (diff == POS_MAX) ? POS_MAX : diff + 1'b1;
    if (len < POS_WIDTH'(m_minrun)) return;
    if (hd_valid && hd_sid == pv_sid) begin
      if (rn_ref0 >= hd_ref0) begin
        dd = rn_ref0 - hd_ref0;
        if (rn_q0 >= hd_q0 && rn_q0 - hd_q0 == dd) begin
          merge = 1'b1;
          newlen = sat_sum(len, dd);
        end
      end else begin
        dd = hd_ref0 - rn_ref0;
        if (hd_q0 > rn_q0 && hd_q0 - rn_q0 == dd) begin
          merge = 1'b1;
          newlen = (len > dd) ? len - dd : '0;
        end
      end
    end
    if (merge) begin
      hd_len = newlen;
      return;
    end
    if (hd_valid) push_held(1'b0);
    hd_valid = 1'b1;
    hd_ref0 = rn_ref0;
    hd_q0 = rn_q0;
    hd_len = len;
    hd_sid = pv_sid;
  endfunction

  // expected block words for one accepted lookup word
  function automatic void chain_step(in_word_t w);
    out_word_t o;
    if (w.end_of_contig) begin
      if (rn_open) close_run();
      if (hd_valid) begin
        push_held(1'b1);
      end else begin
        o = '0;
        o.last_of_contig = 1'b1;
        expect_block(o);
      end
      chain_clear();
      return;
    end
    if (!w.hit_found) return;
    if (pv_hit && pv_sid == w.ref_seq_id && pv_ref != POS_MAX &&
        w.ref_pos == pv_ref + 1'b1) begin
      if (!rn_open) begin
        rn_open = 1'b1;
        rn_ref0 = pv_ref;
        rn_q0 = w.query_pos - 1'b1;
      end
      rn_ref1 = w.ref_pos;
    end else if (rn_open) begin
      close_run();
    end
    pv_hit = 1'b1;
    pv_ref = w.ref_pos;
    pv_sid = w.ref_seq_id;
  endfunction

  function automatic in_word_t mk_word(logic eoc, logic hit, logic [POS_WIDTH-1:0] q,
                                       logic [POS_WIDTH-1:0] r,
                                       logic [SEQ_ID_WIDTH-1:0] sid);
    in_word_t w;
    w.end_of_contig = eoc;
    w.hit_found = hit;
    w.query_pos = q;
    w.ref_pos = r;
    w.ref_seq_id = sid;
    return w;
  endfunction

  function automatic void push_hit(logic [POS_WIDTH-1:0] q, logic [POS_WIDTH-1:0] r,
                                   logic [SEQ_ID_WIDTH-1:0] sid);
    queue_word(mk_word(1'b0, 1'b1, q, r, sid));
    n_work++;
  endfunction

  // a miss carries junk in the ignored fields
  function automatic void push_miss();
    queue_word(mk_word(1'b0, 1'b0, $urandom, $urandom, SEQ_ID_WIDTH'($urandom)));
  endfunction

  function automatic void push_eoc();
    queue_word(mk_word(1'b1, 1'($urandom), $urandom, $urandom,
                       SEQ_ID_WIDTH'($urandom)));
    n_work++;
  endfunction

  function automatic logic [POS_WIDTH-1:0] pick_pos();
    case ($urandom_range(0, 5))
      0: return POS_WIDTH'($urandom_range(0, 40));
      1: return POS_MAX - POS_WIDTH'($urandom_range(0, 40));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [SEQ_ID_WIDTH-1:0] pick_sid();
    case ($urandom_range(0, 5)) inside
      0: return '0;
      1: return '1;
      [2:3]: return SEQ_ID_WIDTH'($urandom_range(0, 3));
      default: return SEQ_ID_WIDTH'($urandom);
    endcase
  endfunction

  // one contig of runs along a few diagonals, with misses and junk hits mixed in
  function automatic void add_contig();
    logic [POS_WIDTH-1:0] diag, q, qs;
    logic [SEQ_ID_WIDTH-1:0] sid;
    int n_runs, len;
    sid = pick_sid();
    diag = pick_pos();
    q = pick_pos();
    qs = q;
    n_runs = $urandom_range(1, 6);
    for (int k = 0; k < n_runs; k++) begin
      if (k > 0) begin
        case ($urandom_range(0, 9)) inside
          [0:3]: q = q + POS_WIDTH'($urandom_range(0, 12));
          [4:5]: q = qs - POS_WIDTH'($urandom_range(1, 12));
          [6:7]: begin
            diag = pick_pos();
            q = pick_pos();
          end
          8: begin
            sid = pick_sid();
            q = q + POS_WIDTH'($urandom_range(0, 4));
          end
          default: begin
            for (int j = $urandom_range(1, 3); j > 0; j--)
              push_hit($urandom, $urandom, pick_sid());
          end
        endcase
      end
      qs = q;
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 30) : $urandom_range(1, 6);
      for (int j = 0; j < len; j++) begin
        if ($urandom_range(0, 7) == 0) push_miss();
        push_hit(q, q + diag, sid);
        q = q + 1'b1;
      end
    end
    push_eoc();
  endfunction

  // block idle: wait until nothing is pending and nothing is expected
  task automatic wait_idle();
    while (lookup_q.size() != 0 || in_valid || exp_blocks.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_WIDTH-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_KMER_SIZE) m_kmer = val[KMER_WIDTH-1:0];
    else m_minrun = val[MINRUN_WIDTH-1:0];
  endtask

  task automatic run_phase(logic [KMER_WIDTH-1:0] kmer, logic [MINRUN_WIDTH-1:0] minrun);
    wait_idle();
    write_reg(REG_KMER_SIZE, CFG_WIDTH'(kmer));
    write_reg(REG_MIN_RUN_LENGTH, CFG_WIDTH'(minrun));
    n_work = 0;
    while (n_work < PHASE_WORDS) add_contig();
  endtask

  // driver: offer the next lookup word, predict at acceptance
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) chain_step(in_data);
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (lookup_q.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= lookup_q.pop_front();
          if (!calm && $urandom_range(0, 15) == 0) in_gap <= $urandom_range(1, 19);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each block word against the oldest expectation
  always @(posedge clk) begin
    out_word_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (exp_blocks.size() == 0) begin
          $error("unexpected block word %h", out_data);
          n_fail++;
        end else begin
          e = exp_blocks.pop_front();
          if (out_data.block_valid !== e.block_valid) begin
            $error("block_valid expected %0h got %0h", e.block_valid, out_data.block_valid);
            n_fail++;
          end
          if (out_data.block_ref_start !== e.block_ref_start) begin
            $error("block_ref_start expected %0h got %0h", e.block_ref_start,
                   out_data.block_ref_start);
            n_fail++;
          end
          if (out_data.block_query_start !== e.block_query_start) begin
            $error("block_query_start expected %0h got %0h", e.block_query_start,
                   out_data.block_query_start);
            n_fail++;
          end
          if (out_data.block_length !== e.block_length) begin
            $error("block_length expected %0h got %0h", e.block_length,
                   out_data.block_length);
            n_fail++;
          end
          if (out_data.block_seq_id !== e.block_seq_id) begin
            $error("block_seq_id expected %0h got %0h", e.block_seq_id,
                   out_data.block_seq_id);
            n_fail++;
          end
          if (out_data.last_of_contig !== e.last_of_contig) begin
            $error("last_of_contig expected %0h got %0h", e.last_of_contig,
                   out_data.last_of_contig);
            n_fail++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!calm && $urandom_range(0, 15) == 0) out_gap <= $urandom_range(1, 19);
      end
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("seed_hit_block_chainer_core_tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    chain_clear();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: empty contig, query start wrap, seq change, reference wrap
    queue_word(mk_word(1'b1, 1'b1, POS_MAX, POS_MAX, '1));
    queue_word(mk_word(1'b0, 1'b0, POS_MAX, POS_MAX, '1));
    push_hit(POS_MAX, 32'd10, 16'hFFFF);
    push_hit(32'd0, 32'd11, 16'hFFFF);
    push_hit(32'd1, 32'd12, 16'hFFFF);
    push_hit(32'd2, 32'd13, 16'd0);
    push_hit(32'd5, POS_MAX, 16'd0);
    push_hit(32'd6, 32'd0, 16'd0);
    push_hit(32'd7, 32'd1, 16'd0);
    push_miss();
    push_hit(32'd8, 32'd2, 16'd0);
    push_hit(32'd9, 32'd100, 16'd0);
    // same diagonal further on merges, off diagonal gives two words at flush
    push_hit(32'd16, 32'd10, 16'd0);
    push_hit(32'd17, 32'd11, 16'd0);
    push_hit(32'd0, 32'd500, 16'd0);
    push_hit(32'd1, 32'd501, 16'd0);
    push_eoc();
    // merge over a huge offset, then a saturated length at flush
    push_hit(32'd0, 32'd0, 16'd7);
    push_hit(32'd1, 32'd1, 16'd7);
    push_hit(32'd1000, 32'd1000, 16'd7);
    push_hit(32'hFFFF_FFF0, 32'hFFFF_FFF0, 16'd7);
    push_hit(32'hFFFF_FFF1, 32'hFFFF_FFF1, 16'd7);
    push_hit(32'd5, 32'd5, 16'd7);
    push_eoc();
    // run before the held block on its diagonal, length floored at zero
    push_hit(32'd100, 32'd100, 16'd3);
    push_hit(32'd101, 32'd101, 16'd3);
    push_hit(32'd50, 32'd50, 16'd3);
    push_hit(32'd51, 32'd51, 16'd3);
    push_eoc();

    // random contigs over several register settings
    run_phase(8'd1, 16'd0);
    run_phase(8'd255, 16'hFFFF);
    run_phase(8'd20, 16'd2);
    run_phase(KMER_WIDTH'($urandom_range(1, 255)), MINRUN_WIDTH'($urandom_range(0, 6)));
    run_phase(8'd255, 16'd1);
    run_phase(8'd1, 16'd3);
    wait_idle();
    calm = 1'b1;
    run_phase(KMER_WIDTH'($urandom_range(1, 255)), MINRUN_WIDTH'($urandom_range(1, 4)));

    wait_idle();
    repeat (8) @(posedge clk);
    if (n_fail == 0 && exp_blocks.size() == 0) begin
      $display("seed_hit_block_chainer_core_tb OK");
    end else begin
      $display("seed_hit_block_chainer_core_tb NOT OK");
    end
    $finish;
  end

endmodule
